### hw/rtl/f2h_pkg.sv
// Shared constants and conversion functions for the binary32/binary16 converter.
package f2h_pkg;

  localparam logic FUNC_NARROW = 1'b0;
  localparam logic FUNC_WIDEN  = 1'b1;

  localparam logic [15:0] H_INF      = 16'h7C00;
  localparam logic [15:0] H_QNAN_BIT = 16'h0200;

  // Narrow binary32 to binary16 with round to nearest even.
  function automatic logic [15:0] narrow(input logic [31:0] x);
    logic [15:0] sign;
    logic [7:0]  ef;
    logic [22:0] mant;
    logic [15:0] base;
    logic [12:0] rest;
    logic        inc;
    logic [7:0]  sh;
    logic [23:0] m24;
    logic [23:0] q;
    logic [23:0] rmask;
    logic [23:0] rem;
    logic [23:0] halfpt;
    logic [15:0] r;
    sign = {x[31], 15'd0};
    ef   = x[30:23];
    mant = x[22:0];
    base = '0;
    rest = '0;
    inc  = 1'b0;
    sh   = '0;
    m24  = {1'b1, mant};
    q    = '0;
    rmask  = '0;
    rem    = '0;
    halfpt = '0;
    if (ef == 8'hFF) begin
      r = sign | H_INF | ((mant != '0) ? H_QNAN_BIT : 16'd0);
    end else if (ef > 8'd142) begin
      r = sign | H_INF;
    end else if (ef >= 8'd113) begin
      // exponent rebias: ef - 127 + 15 = ef - 112
      base = {1'b0, 5'(ef - 8'd112), mant[22:13]};
      rest = mant[12:0];
      inc  = (rest > 13'h1000) || ((rest == 13'h1000) && base[0]);
      r    = sign | (base + {15'd0, inc});
    end else if (ef == 8'd0) begin
      r = sign;
    end else begin
      // shift = -1 - (ef - 127) = 126 - ef, here 14..125
      sh = 8'd126 - ef;
      if (sh > 8'd24) begin
        r = sign;
      end else begin
        q      = m24 >> sh[4:0];
        rmask  = (24'd1 << sh[4:0]) - 24'd1;
        rem    = m24 & rmask;
        halfpt = 24'd1 << (sh[4:0] - 5'd1);
        if ((rem > halfpt) || ((rem == halfpt) && q[0]))
          q = q + 24'd1;
        r = sign | q[15:0];
      end
    end
    return r;
  endfunction

  // Widen binary16 to binary32 exactly.
  function automatic logic [31:0] widen(input logic [15:0] h);
    logic [4:0]  ef;
    logic [9:0]  mant;
    logic [3:0]  lz;
    logic [10:0] m;
    logic [31:0] r;
    ef   = h[14:10];
    mant = h[9:0];
    lz   = 4'd0;
    // leading-zero count over the ten mantissa bits
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) lz = 4'(9 - i);
    end
    m = {1'b0, mant} << (lz + 4'd1);
    if (ef == 5'd0) begin
      if (mant == '0)
        r = {h[15], 31'd0};
      else
        r = {h[15], 8'(8'd112 - {4'd0, lz}), m[9:0], 13'd0};
    end else if (ef == 5'd31) begin
      r = {h[15], 8'hFF, mant, 13'd0};
    end else begin
      r = {h[15], 8'({3'd0, ef} + 8'd112), mant, 13'd0};
    end
    return r;
  endfunction

endpackage

### hw/rtl/fp32_fp16_converter_core.sv
// Top level of the binary32/binary16 format converter.
//
// Command channel: drive func and operand with start high; a word is taken
// at any rising edge where start is high and busy is low. busy is tied low,
// so a new word may be issued every cycle.
// func 0 narrows binary32 to binary16 (round to nearest even), result in the
// low 16 bits with the upper half zero; func 1 widens binary16 (operand low
// 16 bits) to binary32 exactly.
// Result channel: result is valid for exactly one cycle with done high, in the
// cycle after the word is taken. Throughput is one word per cycle, with a
// single conversion stage between the command inputs and the result register.
// The receiver cannot stall; each result is taken in the cycle it appears.
// Synchronous reset clears done; the result register is not reset and holds
// its last word between strobes.
module fp32_fp16_converter_core
  import f2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] operand,
  output logic        done,
  output logic [31:0] result
);

  logic [31:0] result_next;

  assign busy = 1'b0;

  // Select the conversion direction.
  always_comb begin
    if (func == FUNC_WIDEN)
      result_next = widen(operand[15:0]);
    else
      result_next = {16'd0, narrow(operand)};
  end

  // Register the result and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start && !busy;
    end
    if (start && !busy)
      result <= result_next;
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done) else $error("missing result strobe");
  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done) else $error("result strobe without command");
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_NARROW) |=> (result[31:16] == 16'd0))
    else $error("narrowed result has upper bits set");

endmodule

### tb/sv/conv_checker.sv
// Checker for the binary32/binary16 converter: predicts and compares each result word.
`timescale 1ns / 100ps
module conv_checker
  import f2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        func,
  input  logic [31:0] operand,
  input  logic        done,
  input  logic [31:0] result,
  output int          fail_count,
  output int          pending
);

  logic [31:0] expected_words[$];

  // Narrow binary32 to binary16, round to nearest even.
  function automatic logic [15:0] to_half(input logic [31:0] x);
    logic [15:0] sgn;
    int          e;
    logic [22:0] mant;
    logic [15:0] base;
    logic [12:0] rest;
    int          sh;
    logic [23:0] m24;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] halfpt;
    sgn  = x[31] ? 16'h8000 : 16'h0000;
    mant = x[22:0];
    e    = int'(x[30:23]) - 127;
    if (x[30:23] == 8'hFF) return sgn | 16'h7C00 | ((mant != 0) ? 16'h0200 : 16'h0);
    if (e > 15) return sgn | 16'h7C00;
    if (e >= -14) begin
      base = {1'b0, 5'(e + 15), mant[22:13]};
      rest = mant[12:0];
      if (rest > 13'h1000 || (rest == 13'h1000 && base[0])) base = base + 16'd1;
      return sgn | base;
    end
    if (x[30:23] == 8'h00) return sgn;
    sh = -1 - e;
    if (sh > 24) return sgn;
    m24    = {1'b1, mant};
    q      = m24 >> sh;
    rem    = m24 & ((24'd1 << sh) - 24'd1);
    halfpt = 24'd1 << (sh - 1);
    if (rem > halfpt || (rem == halfpt && q[0])) q = q + 24'd1;
    return sgn | q[15:0];
  endfunction

  // Widen binary16 to binary32 exactly.
  function automatic logic [31:0] to_single(input logic [15:0] h);
    int          e;
    logic [10:0] m;
    e = -14;
    m = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (m == 0) return {h[15], 31'd0};
      while (!m[10]) begin
        m = m << 1;
        e = e - 1;
      end
      return {h[15], 8'(127 + e), m[9:0], 13'd0};
    end
    if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
  endfunction

  assign pending = expected_words.size();

  // Predict on accepted commands, compare on strobed results.
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", result);
          fail_count <= fail_count + 1;
        end else begin
          if (result !== expected_words[0]) begin
            if (fail_count < 10)
              $display("mismatch: expected %h actual %h", expected_words[0], result);
            fail_count <= fail_count + 1;
          end
          void'(expected_words.pop_front());
        end
      end
      if (start && !busy) begin
        if (func == FUNC_NARROW) expected_words.push_back({16'd0, to_half(operand)});
        else expected_words.push_back(to_single(operand[15:0]));
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
// Stimulus and verdict for the binary32/binary16 converter.
`timescale 1ns / 100ps
module tb_top;
  import f2h_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [31:0] operand = '0;
  logic        busy;
  logic        done;
  logic [31:0] result;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          idle_pct = 0;

  localparam int CYCLE_LIMIT = 200000;

  fp32_fp16_converter_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .operand(operand), .done(done), .result(result)
  );

  conv_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand(operand), .done(done), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort on a runaway run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Issue one word at the current edge after a random idle gap; hold until accepted.
  task automatic send_word(input logic f, input logic [31:0] op);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    func    <= f;
    operand <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random binary32 leaning toward the half range and its edges.
  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v[30:23] = 8'($urandom_range(98, 146));
      1: v[30:23] = 8'($urandom_range(100, 115));
      2: begin
        v[30:23] = 8'($urandom_range(102, 142));
        v[12:0]  = $urandom_range(1) ? 13'h1000 : v[12:0];
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed[$];
    int n;
    directed = {32'h0, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000,
                32'hFF80_0000, 32'h7FC0_0001, 32'hFF80_0001, 32'h477F_E000,
                32'h477F_F000, 32'h4780_0000, 32'h3F80_1000, 32'h3F80_3000,
                32'h3880_0000, 32'h387F_F000, 32'h3380_0000, 32'h3300_0001,
                32'h3300_0000, 32'hB3C0_0000, 32'hFFFF_FFFF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_word(FUNC_NARROW, directed[i]);
    send_word(FUNC_WIDEN, 32'hFFFF_0000);
    send_word(FUNC_WIDEN, 32'h0000_8000);
    send_word(FUNC_WIDEN, 32'hABCD_0001);
    send_word(FUNC_WIDEN, 32'h0000_83FF);
    send_word(FUNC_WIDEN, 32'h0000_7C00);
    send_word(FUNC_WIDEN, 32'h0000_FE01);
    send_word(FUNC_WIDEN, 32'h0000_7BFF);
    // Random phases: no idling, then 65 and 34 percent idle, then no idling again.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 65 : (ph == 2) ? 34 : 0;
      for (n = 0; n < 450; n++) begin
        if ($urandom_range(1)) send_word(FUNC_NARROW, rand_single());
        else send_word(FUNC_WIDEN, $urandom);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
